### hdl/clle_pkg.sv
// Shared types and constants for the cursor linked list engine.
package clle_pkg;

  localparam int unsigned CAPACITY_DEF     = 256;
  localparam int unsigned ELEMENT_BITS_DEF = 32;
  // Wide enough for any legal capacity plus one.
  localparam int unsigned LIM_W            = 17;

  typedef enum logic [3:0] {
    CMD_INS_AFTER  = 4'd0,
    CMD_INS_BEFORE = 4'd1,
    CMD_REMOVE     = 4'd2,
    CMD_UPDATE     = 4'd3,
    CMD_HEAD       = 4'd4,
    CMD_TAIL       = 4'd5,
    CMD_FWD        = 4'd6,
    CMD_BACK       = 4'd7,
    CMD_RETRIEVE   = 4'd8,
    CMD_FIND       = 4'd9,
    CMD_CLEAR      = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_LAST  = 3'd2,
    ST_FIRST = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FWD,
    CELL_BACK,
    CELL_INS,
    CELL_REM,
    CELL_WR
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_ROT,
    S_FHEAD,
    S_SCAN,
    S_RESP
  } seq_state_e;

  typedef struct packed {
    cell_op_e         op;
    logic [LIM_W-1:0] lim;
  } cell_ctl_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] cur_value;
    logic [8:0]  count;
  } res_t;

endpackage

### hdl/cursor_linked_list_engine_unit.sv
// Top level: bounded list with cursor, kept in a rotating ring of cells.
//
// The list lives in a ring of CAPACITY cells that is rotated so the cursor's
// element always sits in cell 0. A request is taken when start is high and
// busy is low; exactly one result follows, shown for one cycle with done_o
// high, and it must be taken then. Insert before, remove of a middle node,
// update, retrieve, clear, forward, backward and every refused request go
// straight to the result state; insert after first steps forward and then
// inserts (into an empty list it inserts at once). Head, tail and remove of
// the last node rotate the ring one cell per cycle. Find rotates to the
// head, scans forward one element per cycle and, with no match, rotates
// back to the old cursor.
module cursor_linked_list_engine_unit import clle_pkg::*; #(
  parameter int unsigned CAPACITY     = CAPACITY_DEF,
  parameter int unsigned ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  cell_ctl_t               ctl;
  logic [ELEMENT_BITS-1:0] wval;
  logic [ELEMENT_BITS-1:0] cell_val [CAPACITY];

  clle_seq #(
    .CAPACITY    (CAPACITY),
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .cell0_i(cell_val[0]),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o),
    .ctl_o  (ctl),
    .wval_o (wval)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    clle_cell #(
      .IDX         (k),
      .ELEMENT_BITS(ELEMENT_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .wval_i (wval),
      .left_i (cell_val[(k + CAPACITY - 1) % CAPACITY]),
      .right_i(cell_val[(k + 1) % CAPACITY]),
      .val_o  (cell_val[k])
    );
  end

endmodule

### hdl/clle_cell.sv
// One ring cell: holds a single list element and trades it with its neighbors.
module clle_cell import clle_pkg::*; #(
  parameter int unsigned IDX          = 0,
  parameter int unsigned ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic [ELEMENT_BITS-1:0] wval_i,
  input  logic [ELEMENT_BITS-1:0] left_i,
  input  logic [ELEMENT_BITS-1:0] right_i,
  output logic [ELEMENT_BITS-1:0] val_o
);

  localparam logic [LIM_W-1:0] Idx  = LIM_W'(IDX);
  localparam logic [LIM_W-1:0] Idx1 = LIM_W'(IDX + 1);

  logic [ELEMENT_BITS-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_FWD:  val_d = right_i;
      CELL_BACK: val_d = left_i;
      CELL_INS: begin
        if (IDX == 0) val_d = wval_i;
        else if (Idx <= ctl_i.lim) val_d = left_i;
      end
      CELL_REM: begin
        if (Idx1 < ctl_i.lim) val_d = right_i;
      end
      CELL_WR: begin
        if (IDX == 0) val_d = wval_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

### hdl/clle_seq.sv
// Command sequencer: tracks cursor position and count, steers the cell ring.
module clle_seq import clle_pkg::*; #(
  parameter int unsigned CAPACITY     = CAPACITY_DEF,
  parameter int unsigned ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  req_t                    req_i,
  input  logic [ELEMENT_BITS-1:0] cell0_i,
  output logic                    busy,
  output logic                    done_o,
  output res_t                    res_o,
  output cell_ctl_t               ctl_o,
  output logic [ELEMENT_BITS-1:0] wval_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  seq_state_e              state_q, state_d;
  logic [IW-1:0]           cpos_q, cpos_d, tgt_q, tgt_d, save_q, save_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [ELEMENT_BITS-1:0] val_q, val_d;
  logic [2:0]              stat_q, stat_d;
  logic                    found_q, found_d;

  logic [CW-1:0]           cpos_ext;
  logic [IW-1:0]           cpos_inc;
  logic                    empty, full, last, match;
  logic [ELEMENT_BITS-1:0] in_val;

  assign cpos_ext = CW'(cpos_q);
  assign cpos_inc = (cpos_q == IW'(CAPACITY - 1)) ? '0 : cpos_q + 1'b1;
  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CW'(CAPACITY));
  assign last     = (cpos_ext == cnt_q - CW'(1));
  assign match    = (cell0_i == val_q);
  assign in_val   = ELEMENT_BITS'(req_i.value);

  // next state
  always_comb begin
    state_d = state_q;
    cpos_d  = cpos_q;
    tgt_d   = tgt_q;
    save_d  = save_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    stat_d  = stat_q;
    found_d = found_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d   = in_val;
          found_d = 1'b0;
          stat_d  = ST_OK;
          state_d = S_RESP;
          case (req_i.cmd) inside
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              if (full) stat_d = ST_FULL;
              else if (req_i.cmd == CMD_INS_AFTER && !empty) begin
                cpos_d  = cpos_inc;
                state_d = S_INS;
              end else cnt_d = cnt_q + CW'(1);
            end
            CMD_REMOVE: begin
              if (empty) stat_d = ST_EMPTY;
              else begin
                cnt_d = cnt_q - CW'(1);
                if (last) begin
                  tgt_d   = '0;
                  state_d = S_ROT;
                end
              end
            end
            CMD_UPDATE, CMD_RETRIEVE: begin
              if (empty) stat_d = ST_EMPTY;
            end
            CMD_HEAD: begin
              if (empty) stat_d = ST_EMPTY;
              else begin
                tgt_d   = '0;
                state_d = S_ROT;
              end
            end
            CMD_TAIL: begin
              if (empty) stat_d = ST_EMPTY;
              else begin
                tgt_d   = IW'(cnt_q - CW'(1));
                state_d = S_ROT;
              end
            end
            CMD_FWD: begin
              if (empty) stat_d = ST_EMPTY;
              else if (last) stat_d = ST_LAST;
              else cpos_d = cpos_inc;
            end
            CMD_BACK: begin
              if (empty) stat_d = ST_EMPTY;
              else if (cpos_q == '0) stat_d = ST_FIRST;
              else cpos_d = cpos_q - 1'b1;
            end
            CMD_FIND: begin
              if (empty) stat_d = ST_EMPTY;
              else begin
                save_d  = cpos_q;
                state_d = S_FHEAD;
              end
            end
            CMD_CLEAR: begin
              cnt_d  = '0;
              cpos_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        cnt_d   = cnt_q + CW'(1);
        state_d = S_RESP;
      end
      S_ROT: begin
        if (cpos_q == tgt_q) state_d = S_RESP;
        else cpos_d = cpos_inc;
      end
      S_FHEAD: begin
        if (cpos_q == '0) state_d = S_SCAN;
        else cpos_d = cpos_inc;
      end
      S_SCAN: begin
        if (match) begin
          found_d = 1'b1;
          state_d = S_RESP;
        end else if (last) begin
          tgt_d   = save_q;
          state_d = S_ROT;
        end else cpos_d = cpos_inc;
      end
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o.op  = CELL_HOLD;
    ctl_o.lim = LIM_W'(cnt_q - cpos_ext);
    wval_o    = (state_q == S_IDLE) ? in_val : val_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_i.cmd) inside
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              if (!full) begin
                if (req_i.cmd == CMD_INS_AFTER && !empty) ctl_o.op = CELL_FWD;
                else ctl_o.op = CELL_INS;
              end
            end
            CMD_REMOVE: if (!empty) ctl_o.op = CELL_REM;
            CMD_UPDATE: if (!empty) ctl_o.op = CELL_WR;
            CMD_FWD:    if (!empty && !last) ctl_o.op = CELL_FWD;
            CMD_BACK:   if (!empty && cpos_q != '0) ctl_o.op = CELL_BACK;
            default: ;
          endcase
        end
      end
      S_INS:   ctl_o.op = CELL_INS;
      S_ROT:   if (cpos_q != tgt_q) ctl_o.op = CELL_FWD;
      S_FHEAD: if (cpos_q != '0) ctl_o.op = CELL_FWD;
      S_SCAN:  if (!match && !last) ctl_o.op = CELL_FWD;
      default: ctl_o.op = CELL_HOLD;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

  assign res_o.status    = stat_q;
  assign res_o.found     = found_q;
  assign res_o.cur_value = empty ? 32'd0 : 32'(cell0_i);
  assign res_o.count     = 9'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cpos_q  <= '0;
      cnt_q   <= '0;
      tgt_q   <= '0;
      save_q  <= '0;
      stat_q  <= ST_OK;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cpos_q  <= cpos_d;
      cnt_q   <= cnt_d;
      tgt_q   <= tgt_d;
      save_q  <= save_d;
      stat_q  <= stat_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### verif/tb_top.sv
// Testbench for the cursor linked list engine: queued command driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_top import clle_pkg::*; ();

  localparam int unsigned CAP = 256;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  cursor_linked_list_engine_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .done_o(done_o), .res_o(res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor state: shadow of the list.
  logic [31:0] lst_val [CAP];
  logic [7:0]  lst_link [CAP];
  logic [7:0]  lst_free [CAP];
  int unsigned lst_free_top, lst_first, lst_last, lst_cur, lst_count;

  req_t pending_req_q[$];
  res_t expected_res_q[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit calm_mode = 1'b0;
  bit hold_sender = 1'b0;

  function automatic void list_init();
    for (int i = 0; i < CAP; i++) lst_free[i] = i[7:0];
    lst_free_top = CAP;
    lst_first = 0; lst_last = 0; lst_cur = 0; lst_count = 0;
  endfunction

  function automatic int unsigned node_before(int unsigned tgt);
    int unsigned p;
    p = lst_first;
    for (int i = 0; i < CAP; i++) begin
      if (lst_link[p] == tgt[7:0]) break;
      p = 32'(lst_link[p]);
    end
    return p;
  endfunction

  function automatic res_t list_apply(req_t rq);
    res_t r;
    logic [31:0] v;
    bit empty;
    int unsigned c, n, p;
    r = '0;
    v = rq.value;
    empty = (lst_count == 0);
    c = lst_cur;
    r.status = ST_OK;
    case (rq.cmd) inside
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (lst_count >= CAP) r.status = ST_FULL;
        else begin
          lst_free_top--;
          n = 32'(lst_free[lst_free_top]);
          if (empty) begin
            lst_val[n] = v; lst_link[n] = '0;
            lst_first = n; lst_last = n; lst_cur = n;
          end else begin
            lst_val[n] = (rq.cmd == CMD_INS_AFTER) ? v : lst_val[c];
            lst_link[n] = lst_link[c];
            lst_link[c] = n[7:0];
            if (lst_last == c) lst_last = n;
            if (rq.cmd == CMD_INS_AFTER) lst_cur = n;
            else lst_val[c] = v;
          end
          lst_count++;
        end
      end
      CMD_REMOVE: begin
        if (empty) r.status = ST_EMPTY;
        else begin
          if (lst_count == 1) begin
            lst_free[lst_free_top] = c[7:0]; lst_free_top++;
            lst_first = 0; lst_last = 0; lst_cur = 0;
          end else if (c == lst_last) begin
            p = node_before(c);
            lst_link[p] = '0;
            lst_last = p;
            lst_cur = lst_first;
            lst_free[lst_free_top] = c[7:0]; lst_free_top++;
          end else begin
            n = 32'(lst_link[c]);
            lst_val[c] = lst_val[n];
            lst_link[c] = lst_link[n];
            if (lst_last == n) lst_last = c;
            lst_free[lst_free_top] = n[7:0]; lst_free_top++;
          end
          lst_count--;
        end
      end
      CMD_UPDATE: if (empty) r.status = ST_EMPTY; else lst_val[c] = v;
      CMD_HEAD: if (empty) r.status = ST_EMPTY; else lst_cur = lst_first;
      CMD_TAIL: if (empty) r.status = ST_EMPTY; else lst_cur = lst_last;
      CMD_FWD: begin
        if (empty) r.status = ST_EMPTY;
        else if (c == lst_last) r.status = ST_LAST;
        else lst_cur = 32'(lst_link[c]);
      end
      CMD_BACK: begin
        if (empty) r.status = ST_EMPTY;
        else if (c == lst_first) r.status = ST_FIRST;
        else lst_cur = node_before(c);
      end
      CMD_RETRIEVE: if (empty) r.status = ST_EMPTY;
      CMD_FIND: begin
        if (empty) r.status = ST_EMPTY;
        else begin
          p = lst_first;
          for (int i = 0; i < lst_count; i++) begin
            if (lst_val[p] == v) begin
              lst_cur = p; r.found = 1'b1; break;
            end
            p = 32'(lst_link[p]);
          end
        end
      end
      CMD_CLEAR: list_init();
      default: ;
    endcase
    r.cur_value = (lst_count == 0) ? '0 : lst_val[lst_cur];
    r.count = lst_count[8:0];
    return r;
  endfunction

  // Value picker: mostly from a small pool so finds hit, sometimes extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9)) inside
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      [2:3]: return $urandom();
      default: return 32'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic push_req(cmd_e c, logic [31:0] v);
    req_t rq;
    rq.cmd = c;
    rq.value = v;
    pending_req_q.push_back(rq);
  endtask

  // Driver: requests change on the falling edge.
  req_t drv_next;
  logic busy_at_rise = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // idle, or previous request taken at the last rising edge
      if (!start || !busy_at_rise) begin
        if (!hold_sender && pending_req_q.size() > 0 &&
            (calm_mode || $urandom_range(0, 99) >= 6)) begin
          drv_next = pending_req_q.pop_front();
          req_i <= drv_next;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Acceptance and result monitor at the rising edge.
  res_t exp_res;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      busy_at_rise <= busy;
      if (start && !busy) expected_res_q.push_back(list_apply(req_i));
      if (done_o) begin
        if (expected_res_q.size() == 0) begin
          $error("unexpected result: status=%0d count=%0d", res_o.status, res_o.count);
          fail_cnt++;
        end else begin
          exp_res = expected_res_q.pop_front();
          if (res_o.status !== exp_res.status) begin
            $error("status exp=%0d act=%0d", exp_res.status, res_o.status); fail_cnt++;
          end
          if (res_o.found !== exp_res.found) begin
            $error("found exp=%0d act=%0d", exp_res.found, res_o.found); fail_cnt++;
          end
          if (res_o.cur_value !== exp_res.cur_value) begin
            $error("cur_value exp=%h act=%h", exp_res.cur_value, res_o.cur_value);
            fail_cnt++;
          end
          if (res_o.count !== exp_res.count) begin
            $error("count exp=%0d act=%0d", exp_res.count, res_o.count); fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("cursor_linked_list_engine_unit: mismatch");
    $finish;
  end

  int unsigned plan_len;
  initial begin
    list_init();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-list errors, inserts, edges, find, clear, bad codes.
    push_req(CMD_REMOVE, '0);   push_req(CMD_UPDATE, '1);  push_req(CMD_HEAD, '0);
    push_req(CMD_TAIL, '0);     push_req(CMD_FWD, '0);     push_req(CMD_BACK, '0);
    push_req(CMD_RETRIEVE, '0); push_req(CMD_FIND, '0);
    push_req(CMD_INS_AFTER, 32'hFFFF_FFFF);
    push_req(CMD_INS_BEFORE, 32'h0);
    push_req(CMD_INS_AFTER, 32'hA5A5_5A5A);
    push_req(CMD_FWD, '0);      push_req(CMD_BACK, '0);    push_req(CMD_BACK, '0);
    push_req(CMD_BACK, '0);     push_req(CMD_TAIL, '0);    push_req(CMD_FIND, 32'h0);
    push_req(CMD_FIND, 32'h1234_5678);
    push_req(CMD_UPDATE, 32'h5A5A_A5A5);
    push_req(cmd_e'(4'd11), '0); push_req(cmd_e'(4'd15), '1);
    push_req(CMD_TAIL, '0);     push_req(CMD_REMOVE, '0);  push_req(CMD_REMOVE, '0);
    push_req(CMD_CLEAR, '0);
    while (pending_req_q.size() > 0 || start || expected_res_q.size() > 0)
      @(posedge clk_i);

    // Fill to capacity to reach the full-list case, then remove one and clear.
    // This whole stretch runs without sender idling.
    calm_mode = 1'b1;
    for (int i = 0; i < CAP; i++) push_req(i % 2 ? CMD_INS_BEFORE : CMD_INS_AFTER, $urandom());
    push_req(CMD_INS_AFTER, '1); push_req(CMD_INS_BEFORE, '1);
    push_req(CMD_FIND, 32'hFFFF_FFFF); push_req(CMD_TAIL, '0); push_req(CMD_REMOVE, '0);
    push_req(CMD_BACK, '0); push_req(CMD_CLEAR, '0);
    while (pending_req_q.size() > 0 || start || expected_res_q.size() > 0)
      @(posedge clk_i);
    calm_mode = 1'b0;

    // Random: inserts outweigh removes so the list grows; all commands mixed.
    plan_len = 160;
    for (int i = 0; i < plan_len; i++) begin
      if (i == 80) begin
        // after every outstanding result is back, the sender pauses
        while (pending_req_q.size() > 0 || start || expected_res_q.size() > 0)
          @(posedge clk_i);
        hold_sender = 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      case ($urandom_range(0, 19)) inside
        [0:3]:   push_req(CMD_INS_AFTER, pick_value());
        [4:6]:   push_req(CMD_INS_BEFORE, pick_value());
        [7:8]:   push_req(CMD_REMOVE, pick_value());
        9:       push_req(CMD_UPDATE, pick_value());
        10:      push_req(CMD_HEAD, pick_value());
        11:      push_req(CMD_TAIL, pick_value());
        [12:13]: push_req(CMD_FWD, pick_value());
        14:      push_req(CMD_BACK, pick_value());
        15:      push_req(CMD_RETRIEVE, pick_value());
        [16:17]: push_req(CMD_FIND, pick_value());
        18:      push_req(($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_RETRIEVE, $urandom());
        default: push_req(cmd_e'(4'($urandom_range(11, 15))), $urandom());
      endcase
    end

    while (pending_req_q.size() > 0 || start || expected_res_q.size() > 0) @(posedge clk_i);
    repeat (2 * CAP + 10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("cursor_linked_list_engine_unit: match");
    end else begin
      $display("cursor_linked_list_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
